### sv/ohash_pkg.sv
package ohash_pkg;

    typedef enum logic [2:0] {
        CMD_INSERT    = 3'd0,
        CMD_DELETE    = 3'd1,
        CMD_SEARCH    = 3'd2,
        CMD_VAL_EXIST = 3'd3,
        CMD_SEARCH_KV = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        RES_INSERTED = 3'd0,
        RES_UPDATED  = 3'd1,
        RES_REMOVED  = 3'd2,
        RES_FOUND    = 3'd3,
        RES_NOTFOUND = 3'd4,
        RES_FULL     = 3'd5
    } t_res;

    localparam logic [1:0] BST_EMPTY    = 2'd0;
    localparam logic [1:0] BST_OCCUPIED = 2'd1;
    localparam logic [1:0] BST_DELETED  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_MOD,
        S_RD,
        S_WAIT,
        S_EVAL,
        S_WRITE,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic clr_step;   // write empty at probe address, advance
        logic load;       // latch item, start modulo
        logic mod_step;   // one restoring-division step
        logic probe_init; // probe address from remainder or zero
        logic rd;         // issue memory read
        logic eval;       // evaluate registered read data
        logic wr;         // commit write for insert/delete
        logic done;       // present result
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic mod_last;
        logic stop;       // probe finished after eval
        logic need_wr;
    } t_sts;

endpackage

### sv/open_addressing_hash_table.sv
// channel | ports                                      | handshake
// cmd in  | i_cmd, i_key, i_value_in                   | i_start & !o_busy
// result  | o_status, o_value_out, o_slot_index,       | o_valid, one cycle
//         | o_entry_count                              |
// config  | i_cfg_data                                 | i_cfg_we
// an item runs a bit-serial modulo of the key, then reads and evaluates each bucket
// probed through the registered memory read, then writes and presents the result
// after reset a clearing pass empties the status memory;
// o_busy stays high until it ends
// results are shown for one cycle with o_valid; the receiver cannot stall
module open_addressing_hash_table import ohash_pkg::*; #(
    parameter int CAPACITY = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [2:0]  i_cmd,
    input  logic [31:0] i_key,
    input  logic [31:0] i_value_in,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_data,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [31:0] o_value_out,
    output logic [7:0]  o_slot_index,
    output logic [8:0]  o_entry_count
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    t_ctl ctl;
    t_sts sts;

    ohash_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (o_busy),
        .o_done  (o_valid)
    );

    ohash_datapath #(.CAPACITY(CAPACITY), .AW(AW), .CW(CW)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .o_sts         (sts),
        .i_cmd         (i_cmd),
        .i_key         (i_key),
        .i_value_in    (i_value_in),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .o_status      (o_status),
        .o_value_out   (o_value_out),
        .o_slot_index  (o_slot_index),
        .o_entry_count (o_entry_count)
    );

endmodule

### sv/ohash_datapath.sv
module ohash_datapath import ohash_pkg::*; #(
    parameter int CAPACITY = 256,
    parameter int AW       = 8,
    parameter int CW       = 9
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_ctl          i_ctl,
    output t_sts          o_sts,
    input  logic [2:0]    i_cmd,
    input  logic [31:0]   i_key,
    input  logic [31:0]   i_value_in,
    input  logic          i_cfg_we,
    input  logic [8:0]    i_cfg_data,
    output logic [2:0]    o_status,
    output logic [31:0]   o_value_out,
    output logic [7:0]    o_slot_index,
    output logic [8:0]    o_entry_count
);

    localparam int MOD_STEPS = 32;

    logic [1:0]  r_st_mem  [CAPACITY];
    logic [31:0] r_key_mem [CAPACITY];
    logic [31:0] r_val_mem [CAPACITY];

    logic [CW-1:0] r_n, r_count;
    logic [2:0]    r_cmd;
    logic [31:0]   r_key, r_val;
    logic [31:0]   r_quo;
    logic [CW:0]   r_rem;
    logic [5:0]    r_mstep;
    logic [AW-1:0] r_addr;
    logic [CW-1:0] r_visits;
    logic [1:0]    r_rd_st;
    logic [31:0]   r_rd_key, r_rd_val;
    logic          r_free_ok, r_hit;
    logic [AW-1:0] r_free, r_slot;
    logic [2:0]    r_res;
    logic [31:0]   r_vout;
    logic          r_stop;

    logic [CW-1:0] cfg_clamped;
    logic [CW:0]   rem_shift;
    logic [CW-1:0] addr_ext;
    logic [CW-1:0] addr_nxt;
    logic [CW-1:0] count_nxt;

    always_comb begin
        if (i_cfg_data == '0) cfg_clamped = CW'(1);
        else if ({23'd0, i_cfg_data} > 32'(CAPACITY)) cfg_clamped = CW'(CAPACITY);
        else cfg_clamped = CW'(i_cfg_data);
    end

    assign rem_shift = {r_rem[CW-1:0], r_quo[31]};
    assign addr_ext  = CW'(r_addr);
    assign addr_nxt  = (addr_ext + CW'(1) == r_n) ? '0 : addr_ext + CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n     <= CW'(CAPACITY);
            r_count <= '0;
            r_addr  <= '0;
        end else begin
            if (i_cfg_we && r_count == '0) r_n <= cfg_clamped;
            if (i_ctl.clr_step) r_addr <= r_addr + AW'(1);
            if (i_ctl.probe_init) r_addr <= (r_cmd == CMD_VAL_EXIST) ? '0 : AW'(r_rem);
            if (i_ctl.eval) r_addr <= AW'(addr_nxt);
            if (i_ctl.wr) r_count <= count_nxt;
        end
    end

    // item latch, modulo unit, probe bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd   <= i_cmd;
            r_key   <= i_key;
            r_val   <= i_value_in;
            r_quo   <= i_key;
            r_rem   <= '0;
            r_mstep <= '0;
        end
        if (i_ctl.mod_step) begin
            r_mstep <= r_mstep + 6'd1;
            r_quo   <= {r_quo[30:0], 1'b0};
            r_rem   <= (rem_shift >= {1'b0, r_n}) ? rem_shift - {1'b0, r_n} : rem_shift;
        end
        if (i_ctl.probe_init) begin
            r_visits  <= '0;
            r_free_ok <= 1'b0;
            r_hit     <= 1'b0;
            r_stop    <= 1'b0;
            r_free    <= '0;
            r_slot    <= '0;
        end
        if (i_ctl.eval) begin
            r_visits <= r_visits + CW'(1);
            case (r_cmd)
                CMD_INSERT: begin
                    if (r_rd_st == BST_OCCUPIED && r_rd_key == r_key) begin
                        r_hit <= 1'b1; r_slot <= r_addr; r_stop <= 1'b1;
                    end else begin
                        if (r_rd_st != BST_OCCUPIED && !r_free_ok) begin
                            r_free_ok <= 1'b1; r_free <= r_addr;
                        end
                        if (r_visits + CW'(1) == r_n) r_stop <= 1'b1;
                    end
                end
                CMD_DELETE, CMD_SEARCH, CMD_SEARCH_KV: begin
                    if (r_rd_st == BST_EMPTY) r_stop <= 1'b1;
                    else if (r_rd_st == BST_OCCUPIED && r_rd_key == r_key) begin
                        r_hit <= 1'b1; r_slot <= r_addr; r_stop <= 1'b1;
                        r_vout <= r_rd_val;
                    end else if (r_visits + CW'(1) == r_n) r_stop <= 1'b1;
                end
                CMD_VAL_EXIST: begin
                    if (r_rd_st == BST_OCCUPIED && r_rd_val == r_val) begin
                        r_hit <= 1'b1; r_slot <= r_addr; r_stop <= 1'b1;
                        r_vout <= r_rd_val;
                    end else if (r_visits + CW'(1) == r_n) r_stop <= 1'b1;
                end
                default: r_stop <= 1'b1;
            endcase
        end
    end

    // result code resolved once probing stops
    always_comb begin
        case (r_cmd)
            CMD_INSERT: r_res = r_hit ? RES_UPDATED : (r_free_ok ? RES_INSERTED : RES_FULL);
            CMD_DELETE: r_res = r_hit ? RES_REMOVED : RES_NOTFOUND;
            CMD_SEARCH, CMD_VAL_EXIST: r_res = r_hit ? RES_FOUND : RES_NOTFOUND;
            CMD_SEARCH_KV: r_res = (r_hit && r_vout == r_val) ? RES_FOUND : RES_NOTFOUND;
            default: r_res = RES_NOTFOUND;
        endcase
    end

    // occupied count once this word is committed
    always_comb begin
        count_nxt = r_count;
        if (r_res == RES_INSERTED) count_nxt = r_count + CW'(1);
        else if (r_res == RES_REMOVED) count_nxt = r_count - CW'(1);
    end

    logic [AW-1:0] wr_addr;
    assign wr_addr = (r_cmd == CMD_INSERT && !r_hit) ? r_free : r_slot;

    // bucket status memory: clear, write and registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr_step) r_st_mem[r_addr] <= BST_EMPTY;
        if (i_ctl.wr) begin
            if (r_cmd == CMD_DELETE) r_st_mem[wr_addr] <= BST_DELETED;
            else r_st_mem[wr_addr] <= BST_OCCUPIED;
        end
        if (i_ctl.rd) r_rd_st <= r_st_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr && r_cmd == CMD_INSERT) begin
            r_key_mem[wr_addr] <= r_key;
            r_val_mem[wr_addr] <= r_val;
        end
        if (i_ctl.rd) begin
            r_rd_key <= r_key_mem[r_addr];
            r_rd_val <= r_val_mem[r_addr];
        end
    end

    logic found;
    assign found = (r_res == RES_FOUND);

    always_ff @(posedge i_clk) begin
        if (i_ctl.done) begin
            o_status      <= r_res;
            o_value_out   <= found ? r_vout : '0;
            o_slot_index  <= (r_res == RES_NOTFOUND || r_res == RES_FULL) ? 8'd0 :
                             8'(wr_addr);
            o_entry_count <= 9'(count_nxt);
        end
    end

    assign o_sts.clr_last = (r_addr == AW'(CAPACITY - 1));
    assign o_sts.mod_last = (r_mstep == 6'(MOD_STEPS - 1));
    assign o_sts.stop     = r_stop;
    assign o_sts.need_wr  = (r_res == RES_INSERTED || r_res == RES_UPDATED ||
                             r_res == RES_REMOVED);

    property p_count_bound;
        @(posedge i_clk) disable iff (!i_rst_n) r_count <= CW'(CAPACITY);
    endproperty
    a_count_bound: assert property (p_count_bound) else $error("count overflow");

    property p_n_range;
        @(posedge i_clk) disable iff (!i_rst_n) r_n != '0 && r_n <= CW'(CAPACITY);
    endproperty
    a_n_range: assert property (p_n_range) else $error("bucket count out of range");

    property p_visits;
        @(posedge i_clk) disable iff (!i_rst_n) i_ctl.eval |-> r_visits < r_n;
    endproperty
    a_visits: assert property (p_visits) else $error("probe overran");

endmodule

### sv/ohash_ctrl.sv
module ohash_ctrl import ohash_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_ctl o_ctl,
    output logic o_busy,
    output logic o_done
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLEAR;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_busy  = 1'b1;
        o_done  = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_ctl.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                o_ctl.mod_step = 1'b1;
                if (i_sts.mod_last) n_state = S_RD;
            end
            S_RD: begin
                o_ctl.probe_init = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                o_ctl.rd = 1'b1;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (i_sts.stop) n_state = S_WRITE;
                else begin
                    o_ctl.eval = 1'b1;
                    n_state = S_WAIT;
                end
            end
            S_WRITE: begin
                o_ctl.wr   = i_sts.need_wr;
                o_ctl.done = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                o_done = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    property p_done_after_write;
        @(posedge i_clk) disable iff (!i_rst_n) r_state == S_WRITE |=> o_done;
    endproperty
    a_done_after_write: assert property (p_done_after_write) else $error("missing strobe");

    property p_idle_not_busy;
        @(posedge i_clk) disable iff (!i_rst_n) o_done |-> o_busy;
    endproperty
    a_idle_not_busy: assert property (p_idle_not_busy) else $error("strobe while idle");

    property p_load_only_idle;
        @(posedge i_clk) disable iff (!i_rst_n) o_ctl.load |-> !o_busy;
    endproperty
    a_load_only_idle: assert property (p_load_only_idle) else $error("load while busy");

endmodule

### tb/hash_table_checker.sv
module hash_table_checker import ohash_pkg::*; #(
    parameter int CAPACITY = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [2:0]  i_cmd,
    input  logic [31:0] i_key,
    input  logic [31:0] i_value_in,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_data,
    input  logic        i_valid,
    input  logic [2:0]  i_status,
    input  logic [31:0] i_value_out,
    input  logic [7:0]  i_slot_index,
    input  logic [8:0]  i_entry_count,
    output int          o_errors,
    output int          o_pending,
    output int          o_words_checked,
    output int          o_entries
);

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value;
        logic [7:0]  slot;
        logic [8:0]  count;
    } t_answer;

    logic [1:0]  tbl_state [CAPACITY];
    logic [31:0] tbl_key   [CAPACITY];
    logic [31:0] tbl_val   [CAPACITY];
    int          live_entries;
    int          hash_size;
    t_answer     answers_due [$];

    function automatic int clamp_size(logic [8:0] v);
        if (v == 0) return 1;
        if (v > CAPACITY) return CAPACITY;
        return int'(v);
    endfunction

    function automatic int lookup_key(logic [31:0] k);
        int i;
        i = int'(k % hash_size);
        for (int j = 0; j < hash_size; j++) begin
            if (tbl_state[i] == BST_EMPTY) return -1;
            if (tbl_state[i] == BST_OCCUPIED && tbl_key[i] == k) return i;
            i = (i + 1 == hash_size) ? 0 : i + 1;
        end
        return -1;
    endfunction

    function automatic t_answer apply_command(logic [2:0] c, logic [31:0] k, logic [31:0] v);
        t_answer a;
        int      i, pos, free_slot;
        bit      done;
        a = '{RES_NOTFOUND, 32'd0, 8'd0, 9'd0};
        case (c)
            CMD_INSERT: begin
                free_slot = -1;
                done = 0;
                i = int'(k % hash_size);
                for (int j = 0; j < hash_size && !done; j++) begin
                    if (tbl_state[i] == BST_OCCUPIED) begin
                        if (tbl_key[i] == k) begin
                            tbl_val[i] = v;
                            a.status = RES_UPDATED;
                            a.slot = 8'(i);
                            done = 1;
                        end
                    end else if (free_slot < 0) begin
                        free_slot = i;
                    end
                    if (!done) i = (i + 1 == hash_size) ? 0 : i + 1;
                end
                if (!done) begin
                    if (free_slot >= 0) begin
                        tbl_state[free_slot] = BST_OCCUPIED;
                        tbl_key[free_slot] = k;
                        tbl_val[free_slot] = v;
                        live_entries++;
                        a.status = RES_INSERTED;
                        a.slot = 8'(free_slot);
                    end else begin
                        a.status = RES_FULL;
                    end
                end
            end
            CMD_DELETE: begin
                pos = lookup_key(k);
                if (pos >= 0) begin
                    tbl_state[pos] = BST_DELETED;
                    live_entries--;
                    a.status = RES_REMOVED;
                    a.slot = 8'(pos);
                end
            end
            CMD_SEARCH, CMD_SEARCH_KV: begin
                pos = lookup_key(k);
                if (pos >= 0 && (c == CMD_SEARCH || tbl_val[pos] == v)) begin
                    a.status = RES_FOUND;
                    a.value = tbl_val[pos];
                    a.slot = 8'(pos);
                end
            end
            CMD_VAL_EXIST: begin
                for (int j = 0; j < hash_size; j++) begin
                    if (tbl_state[j] == BST_OCCUPIED && tbl_val[j] == v) begin
                        a.status = RES_FOUND;
                        a.value = v;
                        a.slot = 8'(j);
                        break;
                    end
                end
            end
            default: ;
        endcase
        a.count = 9'(live_entries);
        return a;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            for (int j = 0; j < CAPACITY; j++) tbl_state[j] = BST_EMPTY;
            live_entries = 0;
            hash_size = clamp_size(9'd256);
            answers_due.delete();
            o_errors <= 0;
            o_words_checked <= 0;
        end else begin
            // a result word never comes in the cycle a command is accepted
            if (i_valid) begin
                if (answers_due.size() == 0) begin
                    $display("%0t: unexpected result word status %0d", $time, i_status);
                    o_errors <= o_errors + 1;
                end else begin
                    want = answers_due.pop_front();
                    o_words_checked <= o_words_checked + 1;
                    if (i_status !== want.status || i_value_out !== want.value ||
                        i_slot_index !== want.slot || i_entry_count !== want.count) begin
                        $display("%0t: mismatch expected st=%0d val=%h slot=%0d cnt=%0d",
                                 $time, want.status, want.value, want.slot, want.count);
                        $display("%0t:          actual   st=%0d val=%h slot=%0d cnt=%0d",
                                 $time, i_status, i_value_out, i_slot_index, i_entry_count);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_cfg_we && live_entries == 0) hash_size = clamp_size(i_cfg_data);
            if (i_start && !i_busy)
                answers_due.push_back(apply_command(i_cmd, i_key, i_value_in));
        end
    end

    assign o_pending = answers_due.size();
    assign o_entries = live_entries;

endmodule

### tb/testbench.sv
module testbench;
    import ohash_pkg::*;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic [2:0]  cmd = CMD_INSERT;
    logic [31:0] key = 0;
    logic [31:0] value_in = 0;
    logic        cfg_we = 0;
    logic [8:0]  cfg_data = 0;
    logic        valid;
    logic [2:0]  status;
    logic [31:0] value_out;
    logic [7:0]  slot_index;
    logic [8:0]  entry_count;
    int          errors, pending, checked, entries;
    int          cycles = 0;
    logic [31:0] recent_keys [16];
    logic [31:0] recent_vals [16];
    logic [31:0] placed_keys [$];
    int          words_sent = 0;

    localparam int CYCLE_LIMIT = 3_000_000;

    always #6 clk = ~clk;

    open_addressing_hash_table uut (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .o_busy(busy),
        .i_cmd(cmd), .i_key(key), .i_value_in(value_in),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .o_valid(valid), .o_status(status), .o_value_out(value_out),
        .o_slot_index(slot_index), .o_entry_count(entry_count)
    );

    hash_table_checker chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_busy(busy),
        .i_cmd(cmd), .i_key(key), .i_value_in(value_in),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_valid(valid), .i_status(status), .i_value_out(value_out),
        .i_slot_index(slot_index), .i_entry_count(entry_count),
        .o_errors(errors), .o_pending(pending), .o_words_checked(checked),
        .o_entries(entries)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_word(logic [2:0] c, logic [31:0] k, logic [31:0] v);
        repeat ($urandom_range(0, 9) * ($urandom_range(0, 3) != 0)) @(posedge clk);
        start <= 1;
        cmd <= c;
        key <= k;
        value_in <= v;
        @(posedge clk);
        while (busy) @(posedge clk);
        start <= 0;
        cmd <= 3'($urandom);
        key <= $urandom;
        value_in <= $urandom;
        words_sent++;
    endtask

    task automatic drain();
        while (pending != 0) @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    // delete the recent keys if any entries remain, then set the bucket count
    task automatic set_size(logic [8:0] n);
        drain();
        for (int j = 0; j < 256; j++) begin
            if (entries == 0) break;
            for (int t = 0; t < 16; t++) send_word(CMD_DELETE, recent_keys[t], 0);
            drain();
            break;
        end
        cfg_we <= 1;
        cfg_data <= n;
        @(posedge clk);
        cfg_we <= 0;
        @(posedge clk);
    endtask

    task automatic random_word(int span);
        int          r;
        int          t;
        logic [31:0] k;
        r = $urandom_range(0, 99);
        t = $urandom_range(0, 15);
        k = ($urandom_range(0, 1)) ? recent_keys[t] : $urandom_range(0, span);
        if ($urandom_range(0, 9) == 0) k = $urandom;
        if (r < 40) begin
            recent_keys[t] = k;
            recent_vals[t] = $urandom_range(0, 3) == 0 ? recent_vals[t] : $urandom;
            send_word(CMD_INSERT, k, recent_vals[t]);
            placed_keys.push_back(k);
        end else if (r < 55) send_word(CMD_DELETE, k, $urandom);
        else if (r < 75) send_word(CMD_SEARCH, k, $urandom);
        else if (r < 85) send_word(CMD_VAL_EXIST, 0,
                                   $urandom_range(0, 1) ? recent_vals[t] : $urandom);
        else if (r < 97) send_word(CMD_SEARCH_KV, recent_keys[t],
                                   $urandom_range(0, 1) ? recent_vals[t] : $urandom);
        else send_word(3'($urandom_range(5, 7)), $urandom, $urandom);
    endtask

    initial begin
        logic [8:0] sizes [6];
        sizes = '{9'd0, 9'd1, 9'd2, 9'd7, 9'd300, 9'd256};
        for (int t = 0; t < 16; t++) begin
            recent_keys[t] = t;
            recent_vals[t] = t;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, every command, wrap, tombstones, unknown codes
        send_word(CMD_SEARCH, 32'h0, 0);
        send_word(CMD_INSERT, 32'h8000_0000, 32'h7fff_ffff);
        send_word(CMD_INSERT, 32'h7fff_ffff, 32'h8000_0000);
        send_word(CMD_INSERT, 32'hffff_ffff, 32'hffff_ffff);
        send_word(CMD_INSERT, 32'h0000_00ff, 32'h0);
        send_word(CMD_INSERT, 32'h0000_01ff, 32'h1);
        send_word(CMD_INSERT, 32'h8000_0000, 32'h5);
        send_word(CMD_SEARCH, 32'h0000_01ff, 0);
        send_word(CMD_DELETE, 32'hffff_ffff, 0);
        send_word(CMD_SEARCH, 32'h0000_01ff, 0);
        send_word(CMD_DELETE, 32'hffff_ffff, 0);
        send_word(CMD_INSERT, 32'h0000_02ff, 32'h2);
        send_word(CMD_VAL_EXIST, 0, 32'h8000_0000);
        send_word(CMD_VAL_EXIST, 0, 32'h1234_5678);
        send_word(CMD_SEARCH_KV, 32'h7fff_ffff, 32'h8000_0000);
        send_word(CMD_SEARCH_KV, 32'h7fff_ffff, 32'h0);
        send_word(3'd5, 32'h1, 32'h1);
        send_word(3'd7, 32'hffff_ffff, 32'hffff_ffff);
        // write a size while the table holds entries so the size write is ignored
        drain();
        cfg_we <= 1;
        cfg_data <= 9'd3;
        @(posedge clk);
        cfg_we <= 0;
        send_word(CMD_INSERT, 32'h3, 32'h3);

        for (int t = 0; t < 16; t++) recent_keys[t] = 0;
        recent_keys[0] = 32'h8000_0000; recent_keys[1] = 32'h7fff_ffff;
        recent_keys[2] = 32'h0000_00ff; recent_keys[3] = 32'h0000_01ff;
        recent_keys[4] = 32'h0000_02ff; recent_keys[5] = 32'h3;

        for (int p = 0; p < 6; p++) begin
            set_size(sizes[p]);
            for (int t = 0; t < 16; t++) recent_keys[t] = $urandom_range(0, 40);
            placed_keys.delete();
            // fill small tables to the brim to reach the full status
            for (int w = 0; w < 160; w++) begin
                random_word((p < 4) ? 40 : 600);
                if (w == 80) drain();
            end
            // clear everything inserted so the next size can be written
            drain();
            foreach (placed_keys[q]) begin
                if (entries != 0) send_word(CMD_DELETE, placed_keys[q], 0);
            end
            placed_keys.delete();
            drain();
        end
        for (int w = 0; w < 40; w++) random_word(32'hffff_ffff);

        drain();
        $display("sent %0d command words, checked %0d result words", words_sent, checked);
        $display("bucket count writes 0,1,2,7,300 and 256, small tables filled to table full");
        if (errors == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
